@@ sv/assert_macros.svh @@
// Assertion macros shared by the request queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge outside reset.
`define RQCT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RQCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/rqct_pkg.sv @@
// Package: widths, codes and cell control type of the request queue.
package rqct_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_WIDTH    = 16;

  localparam int ACTION_W   = 3;
  localparam int REQ_ID_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int QLEN_W     = 5;
  localparam int ACTIVE_W   = 8;
  localparam logic [ACTIVE_W-1:0] MAX_ACTIVE_RST = 8'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE  = 3'd0,
    ACT_CANCEL   = 3'd1,
    ACT_DISPATCH = 3'd2,
    ACT_CONN_ADD = 3'd3,
    ACT_CONN_REM = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_LIMIT     = 2'd3
  } status_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic enqueue;   // write key into the cell at the tail
    logic cancel;    // compare key, close up behind the first hit
    logic dispatch;  // whole chain shifts one place to the front
  } cell_ctl_t;

endpackage

@@ sv/rqct_cell.sv @@
// One queue slot: holds an id, compares it, and shifts from its rear neighbour.
module rqct_cell import rqct_pkg::*; #(
  parameter int ID_WIDTH = DEF_ID_WIDTH,
  parameter int CNT_W    = 5,
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [ID_WIDTH-1:0] key,
  input  logic [CNT_W-1:0]    count,
  input  logic [ID_WIDTH-1:0] next_id,
  input  logic                found_in,
  output logic [ID_WIDTH-1:0] id_out,
  output logic                found_out
);

  logic [ID_WIDTH-1:0] id_r;
  logic [ID_WIDTH-1:0] id_nxt;
  logic                occupied;
  logic                hit;
  logic                shift;
  logic                load;

  assign occupied  = count > CNT_W'(INDEX);
  assign hit       = ctl.cancel && occupied && (id_r == key);
  assign found_out = found_in | hit;
  assign shift     = ctl.dispatch | (ctl.cancel & found_out);
  assign load      = ctl.enqueue & (count == CNT_W'(INDEX));

  always_comb begin
    id_nxt = id_r;
    if (load) begin
      id_nxt = key;
    end else if (shift) begin
      id_nxt = next_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_out = id_r;

endmodule

@@ sv/request_queue_with_cancel_throttle.sv @@
// Top level: pending-request queue with cancel and active-connection limit.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+---------------------
//  in      | in_action, in_request_id               | in_valid / in_stall
//  out     | out_id, out_dispatched, out_status,    | out_valid / out_stall
//          | out_throttled, out_queue_length, flags |
//  cfg     | cfg_wr_data (max_active)               | cfg_wr_en, no wait
//
// One request per cycle unless stalled: every action finishes in the cycle it is accepted;
// cancel compare and close-up ripple through the cell chain in that cycle.
// The result sits in one output register; a new request is taken whenever
// that register is empty or being emptied, so in_stall = out_valid & out_stall.
// Synchronous active-low reset empties the queue, clears the active count and
// sticky flags and sets max_active to 8; slot contents are not reset.
`include "assert_macros.svh"

module request_queue_with_cancel_throttle import rqct_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [REQ_ID_W-1:0] in_request_id,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [REQ_ID_W-1:0] out_id,
  output logic                out_dispatched,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_throttled,
  output logic [QLEN_W-1:0]   out_queue_length,
  output logic                out_drained_flag,
  output logic                out_more_waiting_flag,
  output logic                out_starvation_flag,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [ACTIVE_W-1:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // control state
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ACTIVE_W-1:0] active_r, active_nxt;
  logic [2:0]          sticky_r, sticky_nxt;   // bit0 drained, bit1 more, bit2 starved
  logic [ACTIVE_W-1:0] max_active_r;
  logic                out_valid_r, out_valid_nxt;

  // result register (no reset needed)
  logic [REQ_ID_W-1:0] out_id_r, out_id_nxt;
  logic                out_disp_r, out_disp_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_thr_r, out_thr_nxt;
  logic [QLEN_W-1:0]   out_qlen_r, out_qlen_nxt;

  logic                accept;
  action_t             act;
  logic                full;
  cell_ctl_t           ctl;
  logic [ID_WIDTH-1:0] key;
  logic [ID_WIDTH-1:0] ids   [QUEUE_DEPTH];
  logic                found [QUEUE_DEPTH+1];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign act      = action_t'(in_action);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign key      = ID_WIDTH'(in_request_id);

  // chain control, decoded from the request and the occupancy count
  assign ctl.enqueue  = accept && (act == ACT_ENQUEUE) && !full;
  assign ctl.cancel   = accept && (act == ACT_CANCEL);
  assign ctl.dispatch = accept && (act == ACT_DISPATCH) && (count_r != '0);

  // cell 0 is the front; each cell pulls from the one behind it
  assign found[0] = 1'b0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] rear_id;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rear_id = '0;
    end else begin : g_mid
      assign rear_id = ids[i+1];
    end
    rqct_cell #(
      .ID_WIDTH (ID_WIDTH),
      .CNT_W    (CNT_W),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key),
      .count     (count_r),
      .next_id   (rear_id),
      .found_in  (found[i]),
      .id_out    (ids[i]),
      .found_out (found[i+1])
    );
  end

  // action decode and result formation
  always_comb begin
    count_nxt      = count_r;
    active_nxt     = active_r;
    sticky_nxt     = sticky_r;
    out_id_nxt     = '0;
    out_disp_nxt   = 1'b0;
    out_status_nxt = ST_OK;
    unique case (act)
      ACT_ENQUEUE: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_CANCEL: begin
        if (found[QUEUE_DEPTH]) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          out_status_nxt = ST_NOT_FOUND;
        end
      end
      ACT_DISPATCH: begin
        if (count_r == '0) begin
          sticky_nxt[2] = 1'b1;
        end else begin
          count_nxt    = count_r - CNT_W'(1);
          out_id_nxt   = REQ_ID_W'(ids[0]);
          out_disp_nxt = 1'b1;
          if (count_r == CNT_W'(1)) begin
            sticky_nxt[0] = 1'b1;
          end else begin
            sticky_nxt[1] = 1'b1;
          end
        end
      end
      ACT_CONN_ADD: begin
        if (active_r >= max_active_r) begin
          out_status_nxt = ST_LIMIT;
        end else begin
          active_nxt = active_r + 8'd1;
        end
      end
      ACT_CONN_REM: begin
        if (active_r == '0) begin
          out_status_nxt = ST_LIMIT;
        end else begin
          active_nxt = active_r - 8'd1;
        end
      end
      default: begin
        // unused codes: no change
      end
    endcase
    out_thr_nxt   = (active_nxt == max_active_r);
    out_qlen_nxt  = QLEN_W'(count_nxt);
    out_valid_nxt = accept | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      active_r     <= '0;
      sticky_r     <= '0;
      max_active_r <= MAX_ACTIVE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r  <= count_nxt;
        active_r <= active_nxt;
        sticky_r <= sticky_nxt;
      end
      if (cfg_wr_en) begin
        max_active_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_id_r     <= out_id_nxt;
      out_disp_r   <= out_disp_nxt;
      out_status_r <= out_status_nxt;
      out_thr_r    <= out_thr_nxt;
      out_qlen_r   <= out_qlen_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_id                = out_id_r;
  assign out_dispatched        = out_disp_r;
  assign out_status            = out_status_r;
  assign out_throttled         = out_thr_r;
  assign out_queue_length      = out_qlen_r;
  assign out_drained_flag      = sticky_r[0];
  assign out_more_waiting_flag = sticky_r[1];
  assign out_starvation_flag   = sticky_r[2];

  // occupancy never passes the depth
  `RQCT_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  // a dispatch from a non-empty queue removes exactly one entry
  `RQCT_ASSERT_NEXT(a_disp_pops, ctl.dispatch, count_r == $past(count_r) - CNT_W'(1))
  // refused connection leaves the active count alone
  `RQCT_ASSERT_NEXT(a_add_refused, accept && (act == ACT_CONN_ADD) && (active_r >= max_active_r), active_r == $past(active_r))
  // a popped id always comes with status ok
  `RQCT_ASSERT_ALWAYS(a_disp_ok, !(out_valid_r && out_disp_r) || (out_status_r == ST_OK))

endmodule

@@ dv/tb_request_queue_with_cancel_throttle.sv @@
// Testbench for the host request queue: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_request_queue_with_cancel_throttle;
  import rqct_pkg::*;

  // Action codes that the block must treat as no-ops.
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam int QUEUE_SLOTS  = DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 10;

  // One result as the block reports it.
  typedef struct packed {
    logic [REQ_ID_W-1:0] id;
    logic                dispatched;
    status_t             status;
    logic                throttled;
    logic [QLEN_W-1:0]   qlen;
    logic                drained;
    logic                more;
    logic                starved;
  } queue_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action = ACT_ENQUEUE;
  logic [REQ_ID_W-1:0] in_request_id = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [REQ_ID_W-1:0] out_id;
  logic                out_dispatched;
  logic [STATUS_W-1:0] out_status;
  logic                out_throttled;
  logic [QLEN_W-1:0]   out_queue_length;
  logic                out_drained_flag;
  logic                out_more_waiting_flag;
  logic                out_starvation_flag;
  logic                cfg_wr_en = 1'b0;
  logic [ACTIVE_W-1:0] cfg_wr_data = '0;

  // Shadow of the block's state, advanced once per accepted request.
  logic [REQ_ID_W-1:0] queued_ids[$];
  int                  live_conns = 0;
  int                  conn_limit = MAX_ACTIVE_RST;
  bit                  drained_seen = 1'b0;
  bit                  more_seen = 1'b0;
  bit                  starved_seen = 1'b0;

  queue_result_t       expected_results[$];
  queue_result_t       got_result;
  queue_result_t       want_result;
  int                  error_count = 0;
  int                  cycle_count = 0;

  // Idling knobs, plus the long receiver hold-off used to back the block up.
  int                  sender_idle_pct = 0;
  int                  recv_stall_pct = 0;
  logic                hold_off = 1'b0;

  request_queue_with_cancel_throttle dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_request_id         (in_request_id),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_id                (out_id),
    .out_dispatched        (out_dispatched),
    .out_status            (out_status),
    .out_throttled         (out_throttled),
    .out_queue_length      (out_queue_length),
    .out_drained_flag      (out_drained_flag),
    .out_more_waiting_flag (out_more_waiting_flag),
    .out_starvation_flag   (out_starvation_flag),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Run guard: a hung handshake must not keep the simulation going forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_request_queue_with_cancel_throttle: FAIL");
      $finish;
    end
  end

  // Receiver: random stall, forced high for the whole hold-off window.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Expected result of one request; updates the shadow state as the block would.
  function automatic queue_result_t predict_queue_result(input logic [ACTION_W-1:0] action,
                                                         input logic [REQ_ID_W-1:0] id);
    queue_result_t r;
    int            hit;
    r = '0;
    hit = -1;
    case (action)
      ACT_ENQUEUE: begin
        if (queued_ids.size() >= QUEUE_SLOTS) r.status = ST_FULL;
        else queued_ids = {queued_ids, id};
      end
      ACT_CANCEL: begin
        // only the oldest copy of an id goes; the rest close up in order
        for (int i = 0; i < queued_ids.size() && hit < 0; i++)
          if (queued_ids[i] == id) hit = i;
        if (hit < 0) r.status = ST_NOT_FOUND;
        else queued_ids.delete(hit);
      end
      ACT_DISPATCH: begin
        if (queued_ids.size() == 0) begin
          starved_seen = 1'b1;
        end else begin
          r.id = queued_ids[0];
          queued_ids.delete(0);
          r.dispatched = 1'b1;
          if (queued_ids.size() == 0) drained_seen = 1'b1;
          else more_seen = 1'b1;
        end
      end
      ACT_CONN_ADD: begin
        if (live_conns >= conn_limit) r.status = ST_LIMIT;
        else live_conns++;
      end
      ACT_CONN_REM: begin
        if (live_conns == 0) r.status = ST_LIMIT;
        else live_conns--;
      end
      default: ;
    endcase
    r.throttled = (live_conns == conn_limit);
    r.qlen = QLEN_W'(queued_ids.size());
    r.drained = drained_seen;
    r.more = more_seen;
    r.starved = starved_seen;
    return r;
  endfunction

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = '{out_id, out_dispatched, status_t'(out_status), out_throttled,
                     out_queue_length, out_drained_flag, out_more_waiting_flag,
                     out_starvation_flag};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result id=%h disp=%b st=%0d len=%0d", got_result.id,
                   got_result.dispatched, got_result.status, got_result.qlen);
      end else begin
        want_result = expected_results[0];
        expected_results.delete(0);
        if (got_result !== want_result) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"mismatch: exp id=%h disp=%b st=%0d thr=%b len=%0d flg=%b%b%b",
                      " | got id=%h disp=%b st=%0d thr=%b len=%0d flg=%b%b%b"},
                     want_result.id, want_result.dispatched, want_result.status,
                     want_result.throttled, want_result.qlen, want_result.drained,
                     want_result.more, want_result.starved,
                     got_result.id, got_result.dispatched, got_result.status,
                     got_result.throttled, got_result.qlen, got_result.drained,
                     got_result.more, got_result.starved);
        end
      end
    end
  end

  // Offer one request, hold it until accepted, then record what should come back.
  task automatic send_request(input logic [ACTION_W-1:0] action,
                              input logic [REQ_ID_W-1:0] id);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= action;
    in_request_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results = {expected_results, predict_queue_result(action, id)};
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_max_active(input logic [ACTIVE_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    conn_limit  = value;
  endtask

  // Fresh out of reset: starved dispatch, removal at zero, default limit, no-op codes.
  task automatic test_empty_after_reset();
    send_request(ACT_DISPATCH, 16'hFFFF);
    send_request(ACT_CONN_REM, 16'h0000);
    send_request(ACT_CONN_ADD, 16'hFFFF);
    send_request(ACT_CONN_REM, 16'h0000);
    send_request(ACT_SPARE_FIRST, 16'hFFFF);
    send_request(ACT_SPARE_LAST, 16'h0000);
    wait_idle();
  endtask

  // Fill to the brim, overflow, cancel (duplicate, absent, tail, head), then drain.
  task automatic test_queue_order();
    send_request(ACT_ENQUEUE, 16'h0000);
    send_request(ACT_ENQUEUE, 16'hFFFF);
    send_request(ACT_ENQUEUE, 16'h5555);
    send_request(ACT_ENQUEUE, 16'hAAAA);
    send_request(ACT_ENQUEUE, 16'h8000);
    send_request(ACT_ENQUEUE, 16'h5555);
    for (int i = 6; i < QUEUE_SLOTS; i++) send_request(ACT_ENQUEUE, REQ_ID_W'(16'h1000 + i));
    send_request(ACT_ENQUEUE, 16'h0BAD);
    send_request(ACT_CANCEL, 16'h5555);
    send_request(ACT_CANCEL, 16'h7777);
    send_request(ACT_CANCEL, REQ_ID_W'(16'h1000 + QUEUE_SLOTS - 1));
    send_request(ACT_CANCEL, 16'h0000);
    while (queued_ids.size() != 0) send_request(ACT_DISPATCH, 16'h0000);
    send_request(ACT_DISPATCH, 16'h0000);
    wait_idle();
  endtask

  // Active count at the limit, at zero, with the limit lowered and at both extremes.
  task automatic test_connection_limits();
    write_max_active(8'd1);
    send_request(ACT_CONN_ADD, 16'h0000);
    send_request(ACT_CONN_ADD, 16'h0000);
    send_request(ACT_CONN_REM, 16'h0000);
    send_request(ACT_CONN_REM, 16'h0000);
    write_max_active(8'd10);
    repeat (10) send_request(ACT_CONN_ADD, REQ_ID_W'($urandom()));
    // limit now below the count: not throttled, adds refused, removals still count
    write_max_active(8'd3);
    send_request(ACT_CONN_ADD, 16'h0000);
    repeat (11) send_request(ACT_CONN_REM, REQ_ID_W'($urandom()));
    write_max_active(8'd255);
    repeat (256) send_request(ACT_CONN_ADD, REQ_ID_W'($urandom()));
    repeat (255) send_request(ACT_CONN_REM, REQ_ID_W'($urandom()));
    wait_idle();
  endtask

  // Mostly sensible traffic: cancels usually hit a queued id, bursts lean to fill or drain.
  task automatic run_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int                  pick;
    bit                  filling;
    logic [ACTION_W-1:0] action;
    logic [REQ_ID_W-1:0] id;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 48 == 0) filling = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      // small ids collide often, giving duplicates in the queue
      id = ($urandom_range(0, 3) == 0) ? REQ_ID_W'($urandom_range(0, 7)) : REQ_ID_W'($urandom());
      if (pick < (filling ? 45 : 20)) begin
        action = ACT_ENQUEUE;
      end else if (pick < 60) begin
        action = ACT_CANCEL;
        if (queued_ids.size() != 0 && $urandom_range(0, 3) != 0)
          id = queued_ids[$urandom_range(0, queued_ids.size() - 1)];
      end else if (pick < 82) begin
        action = ACT_DISPATCH;
      end else if (pick < 91) begin
        action = ACT_CONN_ADD;
      end else if (pick < 98) begin
        action = ACT_CONN_REM;
      end else begin
        action = ACTION_W'(ACT_SPARE_FIRST + $urandom_range(0, ACT_SPARE_LAST - ACT_SPARE_FIRST));
      end
      send_request(action, id);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    write_max_active(MAX_ACTIVE_RST);
    run_random_traffic(200, 0, 0);
    write_max_active(ACTIVE_W'($urandom_range(2, 6)));
    run_random_traffic(200, 53, 0);
    write_max_active(8'd1);
    run_random_traffic(200, 0, 53);
    write_max_active(8'd255);
    run_random_traffic(200, 18, 18);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  // Receiver holds off while requests keep coming, so the block backs up and stalls.
  task automatic test_backpressure();
    write_max_active(8'd4);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_random_traffic(60, 0, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_after_reset();
    test_queue_order();
    test_connection_limits();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_request_queue_with_cancel_throttle: PASS");
    end else begin
      $display("tb_request_queue_with_cancel_throttle: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rqct_pkg.sv
sv/rqct_cell.sv
sv/request_queue_with_cancel_throttle.sv
dv/tb_request_queue_with_cancel_throttle.sv
